/* rtl/yuyv_to_bgr_decimating_core_assert.svh */
// ----------------------------------------------------------------------------
// YUYV to BGR core assertion macros
// Clocked property shorthands for the core's checks, sampled on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_BGR_DECIMATING_CORE_ASSERT_SVH
`define YUYV_TO_BGR_DECIMATING_CORE_ASSERT_SVH

// Same-cycle implication.
`define YBD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define YBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/ybd_pkg.sv */
// ----------------------------------------------------------------------------
// YUYV to BGR package
// Shared constants, register indexes and types of the converter core.
// ----------------------------------------------------------------------------
package ybd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W  = 13;
  localparam int LOG2_W = 3;
  localparam int SUM_W  = 19;

  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [LOG2_W-1:0] RST_RESIZE_LOG2  = 3'd0;
  localparam logic [LOG2_W-1:0] MAX_RESIZE_LOG2  = 3'd4;

  // BT.601 integer coefficients
  localparam logic signed [SUM_W-1:0] K_Y   = 19'sd298;
  localparam logic signed [SUM_W-1:0] K_RV  = 19'sd409;
  localparam logic signed [SUM_W-1:0] K_BU  = 19'sd516;
  localparam logic signed [SUM_W-1:0] K_GU  = 19'sd100;
  localparam logic signed [SUM_W-1:0] K_GV  = 19'sd208;
  localparam logic signed [SUM_W-1:0] K_RND = 19'sd128;
  localparam logic signed [9:0] Y_OFS = 10'sd16;
  localparam logic signed [9:0] C_OFS = 10'sd128;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_RESIZE_LOG2  = 2'd2,
    REG_SWAP_RB      = 2'd3
  } ybd_reg_e;

  // Per-word control carried alongside the payload
  typedef struct packed {
    logic pair;        // word yields two pixels
    logic last_frame;  // word holds the final pixel of the output frame
  } ybd_ctrl_t;

  // Unclamped, unshifted channel sums of one pixel
  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } ybd_sums_t;

endpackage

/* rtl/yuyv_to_bgr_decimating_core.sv */
// ----------------------------------------------------------------------------
// YUYV to BGR decimating converter core
// Converts packed 4:2:2 words to 8-bit BGR pixels with optional 2^k downscale.
// ----------------------------------------------------------------------------
// Usage:
//   Feed raster-order YUYV words on the s_axis channel, one word per handshake.
//   Pixels leave on m_axis, one per output handshake; tlast marks the last pixel
//   a word produced, tuser the last pixel of the output frame. Write registers
//   through the cfg channel only while the core is idle; cfg_ready_o is high.
//   A word passes the input stage at acceptance, then the lane sums, then the
//   output register; at factor 1 the second pixel of the word follows the
//   first. Throughput: at factor 1 the single output register emits one pixel
//   per cycle, and a new word enters only after both pixels of the last one;
//   with decimation, and for words that yield no pixel, one word per cycle.
//   Both rates hold only while m_axis_tready is high.
//   Two conversion lanes work on the two lumas of a word in parallel; the
//   merge stage clamps their sums and serializes the pixels.
//   Reset clears the column and row counters and restores the registers to
//   1920 x 1080, factor 1, blue-green-red order. No clearing pass is needed.
//   A stalled receiver holds the output word; the lane stage and the input
//   stage then fill and s_axis_tready drops.
// ----------------------------------------------------------------------------
module yuyv_to_bgr_decimating_core import ybd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // luma_first, chroma_u, luma_second, chroma_v
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // channel_first, channel_green, channel_third
  output logic        m_axis_tlast,   // end_of_run
  output logic        m_axis_tuser    // end_of_frame
);

  `include "yuyv_to_bgr_decimating_core_assert.svh"

  // Counter and size widths follow the largest frame
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = (MAX_WIDTH > 3) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Configuration registers
  logic [CFG_W-1:0]  frame_width_q, frame_height_q;
  logic [LOG2_W-1:0] resize_q;
  logic              swap_q;

  // Position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Input stage
  logic       s1_valid_q, s1_valid_d;
  ybd_ctrl_t  s1_ctrl_q, s1_ctrl_d;
  logic [31:0] s1_data_q;

  logic       accept, s2_load;
  ybd_sums_t  lane0_sums, lane1_sums;

  logic [W_W-1:0]    w, wpr, out_cols, colx, ocol, col_inc, col_mask;
  logic [H_W-1:0]    h, out_rows, rowx, orow, row_inc, row_mask;
  logic [LOG2_W-1:0] k, km1;
  logic              active, emit, last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      resize_q       <= RST_RESIZE_LOG2;
      swap_q         <= 1'b0;
    end else if (cfg_valid_i) begin
      case (ybd_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        REG_RESIZE_LOG2:  resize_q       <= cfg_data_i[LOG2_W-1:0];
        REG_SWAP_RB:      swap_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Word classification at the current position
  always_comb begin
    // saturate the frame size and the factor
    w = (32'(frame_width_q) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(frame_width_q);
    h = (32'(frame_height_q) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(frame_height_q);
    k = (resize_q > MAX_RESIZE_LOG2) ? MAX_RESIZE_LOG2 : resize_q;
    km1 = k - LOG2_W'(1);

    wpr      = w >> 1;
    out_cols = w >> k;
    out_rows = h >> k;
    colx     = W_W'(col_q);
    rowx     = H_W'(row_q);
    ocol     = colx >> km1;
    orow     = rowx >> k;
    col_mask = (W_W'(1) << km1) - W_W'(1);
    row_mask = (H_W'(1) << k) - H_W'(1);

    active = (colx < wpr) && (rowx < h) && (out_rows != '0) && (out_cols != '0);
    if (k == '0) begin
      emit = active;
      last = (rowx == h - H_W'(1)) && (colx == wpr - W_W'(1));
    end else begin
      // keep the first row of each block and every (F/2)-th word in it
      emit = active && ((rowx & row_mask) == '0) && (orow < out_rows) &&
             ((colx & col_mask) == '0) && (ocol < out_cols);
      last = (orow == out_rows - H_W'(1)) && (ocol == out_cols - W_W'(1));
    end

    // advance the raster position, wrap at row and frame end
    col_inc = colx + W_W'(1);
    row_inc = rowx + H_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= wpr) begin
        col_d = '0;
        row_d = (row_inc >= h) ? '0 : ROW_W'(row_inc);
      end else begin
        col_d = COL_W'(col_inc);
      end
    end

    s1_ctrl_d.pair       = (k == '0);
    s1_ctrl_d.last_frame = last;
  end

  // Take a word whenever the input stage is empty or moving on
  assign s_axis_tready = !s1_valid_q || s2_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      // drop words that yield no pixel here
      s1_valid_d = emit;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= s_axis_tdata;
      s1_ctrl_q <= s1_ctrl_d;
    end
  end

  ybd_lane u_lane0 (
    .clk_i      (clk_i),
    .load_i     (s2_load),
    .luma_i     (s1_data_q[7:0]),
    .chroma_u_i (s1_data_q[15:8]),
    .chroma_v_i (s1_data_q[31:24]),
    .sums_o     (lane0_sums)
  );

  ybd_lane u_lane1 (
    .clk_i      (clk_i),
    .load_i     (s2_load),
    .luma_i     (s1_data_q[23:16]),
    .chroma_u_i (s1_data_q[15:8]),
    .chroma_v_i (s1_data_q[31:24]),
    .sums_o     (lane1_sums)
  );

  ybd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_valid_i  (s1_valid_q),
    .word_ctrl_i   (s1_ctrl_q),
    .lane0_i       (lane0_sums),
    .lane1_i       (lane1_sums),
    .swap_i        (swap_q),
    .load_o        (s2_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Frame end only on the last pixel of a word
  `YBD_ASSERT_IMP(a_eof_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  // A waiting word in the input stage is never lost or overwritten
  `YBD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s2_load, s1_valid_q && $stable(s1_data_q))
  // Column counter stays inside the widest row
  `YBD_ASSERT_IMP(a_col_range, 1'b1, 32'(col_q) < ((MAX_WIDTH > 3) ? MAX_WIDTH / 2 : 2))

endmodule

/* rtl/ybd_lane.sv */
// ----------------------------------------------------------------------------
// YUYV to BGR conversion lane
// Forms the three BT.601 channel sums of one pixel and registers them.
// ----------------------------------------------------------------------------
module ybd_lane import ybd_pkg::*; (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic [7:0]      luma_i,
  input  logic [7:0]      chroma_u_i,
  input  logic [7:0]      chroma_v_i,
  output ybd_sums_t       sums_o
);

  logic signed [9:0]       c, d, e;
  logic signed [SUM_W-1:0] cx, dx, ex, yterm;
  ybd_sums_t               sums_d, sums_q;

  always_comb begin
    c     = $signed({2'b00, luma_i}) - Y_OFS;
    d     = $signed({2'b00, chroma_u_i}) - C_OFS;
    e     = $signed({2'b00, chroma_v_i}) - C_OFS;
    cx    = SUM_W'(c);
    dx    = SUM_W'(d);
    ex    = SUM_W'(e);
    yterm = cx * K_Y + K_RND;
    sums_d.r = yterm + ex * K_RV;
    sums_d.g = yterm - dx * K_GU - ex * K_GV;
    sums_d.b = yterm + dx * K_BU;
  end

  // hold unless a new word enters the lane
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

/* rtl/ybd_merge.sv */
// ----------------------------------------------------------------------------
// YUYV to BGR merge stage
// Clamps the lane sums, orders the channels and serializes the pixels of a
// word into the output register.
// ----------------------------------------------------------------------------
module ybd_merge import ybd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        word_valid_i,
  input  ybd_ctrl_t   word_ctrl_i,
  input  ybd_sums_t   lane0_i,
  input  ybd_sums_t   lane1_i,
  input  logic        swap_i,
  output logic        load_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // channel_first, channel_green, channel_third
  output logic        m_axis_tlast,   // end_of_run
  output logic        m_axis_tuser    // end_of_frame
);

  function automatic logic [7:0] clamp8(input logic [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:16]) begin
      res = 8'd255;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

  logic      busy_q, busy_d;
  logic      sel_q, sel_d;
  ybd_ctrl_t ctrl_q;
  logic      ov_q, ov_d;
  logic      out_load, final_pix, busy_free;
  ybd_sums_t pick;
  logic [7:0] r8, g8, b8;
  logic [23:0] data_q;
  logic        last_q, eof_q;

  always_comb begin
    final_pix = !ctrl_q.pair || sel_q;
    out_load  = busy_q && (!ov_q || m_axis_tready);
    busy_free = !busy_q || (out_load && final_pix);
    load_o    = word_valid_i && busy_free;

    busy_d = busy_q;
    sel_d  = sel_q;
    if (load_o) begin
      busy_d = 1'b1;
      sel_d  = 1'b0;
    end else if (out_load) begin
      if (final_pix) begin
        busy_d = 1'b0;
      end else begin
        sel_d = 1'b1;
      end
    end

    ov_d = ov_q;
    if (out_load) begin
      ov_d = 1'b1;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end

    pick = sel_q ? lane1_i : lane0_i;
    r8   = clamp8(pick.r);
    g8   = clamp8(pick.g);
    b8   = clamp8(pick.b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sel_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      sel_q  <= sel_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      ctrl_q <= word_ctrl_i;
    end
    if (out_load) begin
      data_q <= swap_i ? {b8, g8, r8} : {r8, g8, b8};
      last_q <= final_pix;
      eof_q  <= final_pix && ctrl_q.last_frame;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = eof_q;

endmodule
